### hw/rtl/mgm_pkg.sv
// Package for the multicast group membership table.
// Holds field widths, request/result codes, table entry types and helpers.
// Depends on nothing; taken in by the top level, the checker and the testbench.
`default_nettype none

package mgm_pkg;

    localparam int MGM_MAX_GROUPS   = 32;
    localparam int MGM_MAX_SRC      = 8;

    localparam int ADDR_W   = 32;
    localparam int REFS_W   = 16;
    localparam int STATUS_W = 2;
    localparam int RTYPE_W  = 2;
    localparam int MAC_W    = 2;
    localparam int MACLO_W  = 23;
    localparam int COUNT_W  = 6;
    localparam int CFG_AW   = 3;
    localparam int CFG_DW   = 32;

    localparam logic [REFS_W-1:0] REF_MAX = '1;

    // Request function
    localparam logic FUNC_JOIN  = 1'b0;
    localparam logic FUNC_LEAVE = 1'b1;

    // Status codes
    localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_TBL_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_SRC_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd3;

    // Record types
    localparam logic [RTYPE_W-1:0] REC_TO_EXCL = 2'd0;
    localparam logic [RTYPE_W-1:0] REC_ALLOW   = 2'd1;
    localparam logic [RTYPE_W-1:0] REC_TO_INCL = 2'd2;
    localparam logic [RTYPE_W-1:0] REC_BLOCK   = 2'd3;

    // MAC filter actions
    localparam logic [MAC_W-1:0] MAC_NONE   = 2'd0;
    localparam logic [MAC_W-1:0] MAC_ADD    = 2'd1;
    localparam logic [MAC_W-1:0] MAC_REMOVE = 2'd2;

    // Configuration register indexes
    localparam logic REG_ENABLE  = 1'b0;
    localparam logic REG_MAC_ENA = 1'b1;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [REFS_W-1:0] refs;
    } t_grp_ent;

    typedef struct packed {
        logic              vld;
        logic [ADDR_W-1:0] addr;
        logic [REFS_W-1:0] refs;
    } t_src_ent;

    // Saturating reference count increment
    function automatic logic [REFS_W-1:0] ref_inc(input logic [REFS_W-1:0] refs);
        ref_inc = (refs == REF_MAX) ? refs : refs + REFS_W'(1);
    endfunction

endpackage

`default_nettype wire

### hw/rtl/multicast_group_membership_table_top.sv
// Multicast group membership table: join/leave requests against a
// reference-counted group table with per-group source lists.
// Depends on mgm_pkg.
//
//  channel   | ports                                        | handshake
//  ----------+----------------------------------------------+------------------------------
//  request   | i_func, i_group_addr, i_source_addr          | start high, busy low
//  result    | o_status .. o_group_count                    | o_valid, one cycle, no stall
//  config    | psel penable pwrite paddr pwdata prdata      | APB write, pready tied high
//
// Flow: a request is answered after the group scan (one memory read per cycle
// over the G = MAX_GROUPS group entries) and then, where needed, either a
// source scan or a clear sweep over the S = MAX_SOURCES_PER_GROUP source
// slots of the chosen group, both through memories with one read port and
// one write port. A disabled request or a join against a full table skips
// the scans and goes straight to the result.
// Reset: synchronous, active low; clears the group valid bits, the group
// count, the registers (enable and MAC filter enable read 1) and the sequencer.
// Memory contents are not cleared: creating a group sweeps its source slots.
// The receiver cannot stall: each result stands for exactly one cycle.
`default_nettype none

module multicast_group_membership_table_top #(
    parameter int MAX_GROUPS            = mgm_pkg::MGM_MAX_GROUPS,
    parameter int MAX_SOURCES_PER_GROUP = mgm_pkg::MGM_MAX_SRC
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,

    input  wire logic                          start,
    output      logic                          busy,
    input  wire logic                          i_func,
    input  wire logic [mgm_pkg::ADDR_W-1:0]    i_group_addr,
    input  wire logic [mgm_pkg::ADDR_W-1:0]    i_source_addr,

    output      logic                          o_valid,
    output      logic [mgm_pkg::STATUS_W-1:0]  o_status,
    output      logic                          o_send_report,
    output      logic [mgm_pkg::RTYPE_W-1:0]   o_rec_kind,
    output      logic [mgm_pkg::ADDR_W-1:0]    o_report_group,
    output      logic                          o_has_source,
    output      logic [mgm_pkg::ADDR_W-1:0]    o_report_source,
    output      logic [mgm_pkg::MAC_W-1:0]     o_mac_action,
    output      logic [mgm_pkg::MACLO_W-1:0]   o_mac_low_bits,
    output      logic [mgm_pkg::COUNT_W-1:0]   o_group_count,

    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [mgm_pkg::CFG_AW-1:0]    paddr,
    input  wire logic [mgm_pkg::CFG_DW-1:0]    pwdata,
    output      logic [mgm_pkg::CFG_DW-1:0]    prdata,
    output      logic                          pready
);
    import mgm_pkg::*;

    localparam int G   = MAX_GROUPS;
    localparam int S   = MAX_SOURCES_PER_GROUP;
    localparam int SN  = G * S;
    localparam int GW  = (G > 1) ? $clog2(G) : 1;    // group index
    localparam int GCW = $clog2(G + 1);              // group counter / held count
    localparam int SW  = (S > 1) ? $clog2(S) : 1;    // slot within a group
    localparam int SCW = $clog2(S + 1);              // slot counter
    localparam int SAW = (SN > 1) ? $clog2(SN) : 1;  // source memory address

    // Sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_GSCAN = 3'd1;
    localparam logic [2:0] S_CLR   = 3'd2;
    localparam logic [2:0] S_SSCAN = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic r_enable, r_mac_ena;
    logic cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable  <= 1'b1;
            r_mac_ena <= 1'b1;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_ENABLE:  r_enable  <= pwdata[0];
                REG_MAC_ENA: r_mac_ena <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (paddr[2])
            REG_ENABLE:  prdata[0] = r_enable;
            REG_MAC_ENA: prdata[0] = r_mac_ena;
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Memories: group table (address, refs) and source slots
    // ------------------------------------------------------------------
    t_grp_ent r_gmem [G];
    t_src_ent r_smem [SN];
    t_grp_ent r_gq;
    t_src_ent r_sq;

    logic           gm_we;
    logic [GW-1:0]  gm_wa, gm_ra;
    t_grp_ent       gm_wd;
    logic           sm_we;
    logic [SAW-1:0] sm_wa, sm_ra;
    t_src_ent       sm_wd;

    always_ff @(posedge i_clk) begin
        if (gm_we) begin
            r_gmem[gm_wa] <= gm_wd;
        end
        r_gq <= r_gmem[gm_ra];
    end

    always_ff @(posedge i_clk) begin
        if (sm_we) begin
            r_smem[sm_wa] <= sm_wd;
        end
        r_sq <= r_smem[sm_ra];
    end

    // ------------------------------------------------------------------
    // Sequencer state
    // ------------------------------------------------------------------
    logic [2:0]            r_state, n_state;
    logic [G-1:0]          r_gvld, n_gvld;
    logic [GCW-1:0]        r_held, n_held;
    logic                  r_pv, n_pv;          // group read issued last cycle
    logic                  r_spv, n_spv;        // source read issued last cycle
    logic                  r_ffound, n_ffound;  // free group slot seen
    logic                  r_sffound, n_sffound;
    logic                  r_ovalid, n_ovalid;

    // Request payload and working registers
    logic                  r_func, n_func;
    logic [ADDR_W-1:0]     r_grp, n_grp;
    logic [ADDR_W-1:0]     r_src, n_src;
    logic [GCW-1:0]        r_idx, n_idx;
    logic [GW-1:0]         r_pidx, n_pidx;
    logic                  r_pvld, n_pvld;
    logic [GW-1:0]         r_fidx, n_fidx;
    logic [SAW-1:0]        r_sbase, n_sbase;
    logic [SCW-1:0]        r_sidx, n_sidx;
    logic [SW-1:0]         r_psidx, n_psidx;
    logic [SW-1:0]         r_sfidx, n_sfidx;
    logic [STATUS_W-1:0]   r_status, n_status;
    logic                  r_is_new, n_is_new;
    logic                  r_gdel, n_gdel;
    logic                  r_sdel, n_sdel;
    logic [MAC_W-1:0]      r_mac, n_mac;

    // Result registers
    logic [STATUS_W-1:0]   r_o_status, n_o_status;
    logic                  r_o_report, n_o_report;
    logic [RTYPE_W-1:0]    r_o_rtype, n_o_rtype;
    logic [ADDR_W-1:0]     r_o_group, n_o_group;
    logic                  r_o_has_src, n_o_has_src;
    logic [ADDR_W-1:0]     r_o_source, n_o_source;
    logic [MAC_W-1:0]      r_o_mac, n_o_mac;
    logic [MACLO_W-1:0]    r_o_maclo, n_o_maclo;
    logic [COUNT_W-1:0]    r_o_count, n_o_count;

    logic                  g_issue, g_hit, s_issue, s_hit, src_any, rpt;
    logic [GCW+COUNT_W-1:0] held_ext;

    assign busy     = (r_state != S_IDLE);
    assign src_any  = (r_src != '0);
    assign g_issue  = (r_idx < GCW'(G));
    assign g_hit    = r_pv && r_pvld && (r_gq.addr == r_grp);
    assign s_issue  = (r_sidx < SCW'(S));
    assign s_hit    = r_spv && r_sq.vld && (r_sq.addr == r_src);
    assign held_ext = {{COUNT_W{1'b0}}, r_held};

    always_comb begin
        n_state   = r_state;
        n_gvld    = r_gvld;
        n_held    = r_held;
        n_pv      = 1'b0;
        n_spv     = 1'b0;
        n_ffound  = r_ffound;
        n_sffound = r_sffound;
        n_ovalid  = 1'b0;
        n_func    = r_func;
        n_grp     = r_grp;
        n_src     = r_src;
        n_idx     = r_idx;
        n_pidx    = r_pidx;
        n_pvld    = r_pvld;
        n_fidx    = r_fidx;
        n_sbase   = r_sbase;
        n_sidx    = r_sidx;
        n_psidx   = r_psidx;
        n_sfidx   = r_sfidx;
        n_status  = r_status;
        n_is_new  = r_is_new;
        n_gdel    = r_gdel;
        n_sdel    = r_sdel;
        n_mac     = r_mac;

        n_o_status  = r_o_status;
        n_o_report  = r_o_report;
        n_o_rtype   = r_o_rtype;
        n_o_group   = r_o_group;
        n_o_has_src = r_o_has_src;
        n_o_source  = r_o_source;
        n_o_mac     = r_o_mac;
        n_o_maclo   = r_o_maclo;
        n_o_count   = r_o_count;

        gm_we = 1'b0;
        gm_wa = r_pidx;
        gm_wd = r_gq;
        gm_ra = r_idx[GW-1:0];
        sm_we = 1'b0;
        sm_wa = r_sbase + SAW'(r_psidx);
        sm_wd = r_sq;
        sm_ra = r_sbase + SAW'(r_sidx[SW-1:0]);
        rpt   = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_func   = i_func;
                    n_grp    = i_group_addr;
                    n_src    = i_source_addr;
                    n_status = STAT_OK;
                    n_is_new = 1'b0;
                    n_gdel   = 1'b0;
                    n_sdel   = 1'b0;
                    n_mac    = MAC_NONE;
                    n_idx    = '0;
                    n_ffound = 1'b0;
                    if (!r_enable) begin
                        n_state = S_DONE;
                    end else if (i_func == FUNC_JOIN && r_held >= GCW'(G)) begin
                        n_status = STAT_TBL_FULL;
                        n_state  = S_DONE;
                    end else begin
                        n_state = S_GSCAN;
                    end
                end
            end

            S_GSCAN: begin
                // Issue one group read per cycle, compare the one read last cycle
                n_pv   = g_issue;
                n_pidx = r_idx[GW-1:0];
                n_pvld = r_gvld[r_idx[GW-1:0]];
                if (g_issue) begin
                    n_idx = r_idx + GCW'(1);
                    if (!r_gvld[r_idx[GW-1:0]] && !r_ffound) begin
                        n_ffound = 1'b1;
                        n_fidx   = r_idx[GW-1:0];
                    end
                end
                if (g_hit) begin
                    n_sbase   = SAW'(r_pidx) * SAW'(S);
                    n_sidx    = '0;
                    n_sffound = 1'b0;
                    gm_wa     = r_pidx;
                    if (r_func == FUNC_JOIN) begin
                        gm_we      = 1'b1;
                        gm_wd.refs = ref_inc(r_gq.refs);
                    end else if (r_gq.refs <= REFS_W'(1)) begin
                        // Last reference: free the group
                        n_gvld[r_pidx] = 1'b0;
                        n_held         = r_held - GCW'(1);
                        n_mac          = r_mac_ena ? MAC_REMOVE : MAC_NONE;
                        n_gdel         = 1'b1;
                    end else begin
                        gm_we      = 1'b1;
                        gm_wd.refs = r_gq.refs - REFS_W'(1);
                    end
                    n_state = src_any ? S_SSCAN : S_DONE;
                end else if (!r_pv && !g_issue) begin
                    if (r_func == FUNC_LEAVE) begin
                        n_status = STAT_NOT_FOUND;
                        n_state  = S_DONE;
                    end else begin
                        // New group in the first free slot
                        gm_we          = 1'b1;
                        gm_wa          = r_fidx;
                        gm_wd.addr     = r_grp;
                        gm_wd.refs     = REFS_W'(1);
                        n_gvld[r_fidx] = 1'b1;
                        n_held         = r_held + GCW'(1);
                        n_mac          = r_mac_ena ? MAC_ADD : MAC_NONE;
                        n_is_new       = 1'b1;
                        n_sbase        = SAW'(r_fidx) * SAW'(S);
                        n_sidx         = '0;
                        n_state        = S_CLR;
                    end
                end
            end

            S_CLR: begin
                // Sweep the new group's source slots; slot 0 takes the source, if one is given
                sm_we      = 1'b1;
                sm_wa      = r_sbase + SAW'(r_sidx[SW-1:0]);
                sm_wd.vld  = (r_sidx == '0) && src_any;
                sm_wd.addr = r_src;
                sm_wd.refs = REFS_W'(1);
                n_sidx     = r_sidx + SCW'(1);
                if (r_sidx == SCW'(S - 1)) begin
                    n_state = S_DONE;
                end
            end

            S_SSCAN: begin
                n_spv   = s_issue;
                n_psidx = r_sidx[SW-1:0];
                if (s_issue) begin
                    n_sidx = r_sidx + SCW'(1);
                end
                if (r_spv && !r_sq.vld && !r_sffound) begin
                    n_sffound = 1'b1;
                    n_sfidx   = r_psidx;
                end
                if (s_hit) begin
                    sm_we = 1'b1;
                    sm_wa = r_sbase + SAW'(r_psidx);
                    if (r_func == FUNC_JOIN) begin
                        sm_wd.refs = ref_inc(r_sq.refs);
                        n_is_new   = 1'b0;
                    end else if (r_sq.refs <= REFS_W'(1)) begin
                        sm_wd.vld = 1'b0;
                        n_sdel    = 1'b1;
                    end else begin
                        sm_wd.refs = r_sq.refs - REFS_W'(1);
                    end
                    n_state = S_DONE;
                end else if (!r_spv && !s_issue) begin
                    if (r_func == FUNC_JOIN) begin
                        if (r_sffound) begin
                            sm_we      = 1'b1;
                            sm_wa      = r_sbase + SAW'(r_sfidx);
                            sm_wd.vld  = 1'b1;
                            sm_wd.addr = r_src;
                            sm_wd.refs = REFS_W'(1);
                            n_is_new   = 1'b1;
                        end else begin
                            n_status = STAT_SRC_FULL;
                            n_is_new = 1'b0;
                        end
                    end
                    n_state = S_DONE;
                end
            end

            S_DONE: begin
                // Assemble the result and present it for one cycle
                rpt = (r_func == FUNC_JOIN) ? r_is_new : (r_gdel | r_sdel);
                n_ovalid    = 1'b1;
                n_o_status  = r_status;
                n_o_report  = rpt;
                n_o_rtype   = !rpt ? REC_TO_EXCL :
                              (r_func == FUNC_JOIN) ? (src_any ? REC_ALLOW : REC_TO_EXCL)
                                                    : (src_any ? REC_BLOCK : REC_TO_INCL);
                n_o_group   = rpt ? r_grp : '0;
                n_o_has_src = rpt && src_any;
                n_o_source  = (rpt && src_any) ? r_src : '0;
                n_o_mac     = r_mac;
                n_o_maclo   = (r_mac != MAC_NONE) ? r_grp[MACLO_W-1:0] : '0;
                n_o_count   = held_ext[COUNT_W-1:0];
                n_state     = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_gvld    <= '0;
            r_held    <= '0;
            r_pv      <= 1'b0;
            r_spv     <= 1'b0;
            r_ffound  <= 1'b0;
            r_sffound <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_gvld    <= n_gvld;
            r_held    <= n_held;
            r_pv      <= n_pv;
            r_spv     <= n_spv;
            r_ffound  <= n_ffound;
            r_sffound <= n_sffound;
            r_ovalid  <= n_ovalid;
        end
    end

    // Payload and working registers
    always_ff @(posedge i_clk) begin
        r_func      <= n_func;
        r_grp       <= n_grp;
        r_src       <= n_src;
        r_idx       <= n_idx;
        r_pidx      <= n_pidx;
        r_pvld      <= n_pvld;
        r_fidx      <= n_fidx;
        r_sbase     <= n_sbase;
        r_sidx      <= n_sidx;
        r_psidx     <= n_psidx;
        r_sfidx     <= n_sfidx;
        r_status    <= n_status;
        r_is_new    <= n_is_new;
        r_gdel      <= n_gdel;
        r_sdel      <= n_sdel;
        r_mac       <= n_mac;
        r_o_status  <= n_o_status;
        r_o_report  <= n_o_report;
        r_o_rtype   <= n_o_rtype;
        r_o_group   <= n_o_group;
        r_o_has_src <= n_o_has_src;
        r_o_source  <= n_o_source;
        r_o_mac     <= n_o_mac;
        r_o_maclo   <= n_o_maclo;
        r_o_count   <= n_o_count;
    end

    assign o_valid         = r_ovalid;
    assign o_status        = r_o_status;
    assign o_send_report   = r_o_report;
    assign o_rec_kind      = r_o_rtype;
    assign o_report_group  = r_o_group;
    assign o_has_source    = r_o_has_src;
    assign o_report_source = r_o_source;
    assign o_mac_action    = r_o_mac;
    assign o_mac_low_bits  = r_o_maclo;
    assign o_group_count   = r_o_count;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_held_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_gvld) == r_held)
        else $error("group count differs from number of valid groups");

    a_held_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= GCW'(G))
        else $error("group count beyond table size");

    a_no_report_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != STAT_OK) |-> !o_send_report)
        else $error("report sent with error status");

    a_start_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && !o_valid))
        else $error("accepted request did not occupy the sequencer");

    a_valid_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (!busy && $past(r_state == S_DONE)))
        else $error("result strobe without a finished request");

endmodule

`default_nettype wire

### dv/membership_checker.sv
// Checker for the multicast group membership table: watches the request, result
// and APB channels, keeps its own copy of the tables and compares every result.
// Depends on mgm_pkg.
module membership_checker
    import mgm_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    input  wire logic                 busy,
    input  wire logic                 i_func,
    input  wire logic [ADDR_W-1:0]    i_group_addr,
    input  wire logic [ADDR_W-1:0]    i_source_addr,
    input  wire logic                 o_valid,
    input  wire logic [STATUS_W-1:0]  o_status,
    input  wire logic                 o_send_report,
    input  wire logic [RTYPE_W-1:0]   o_rec_kind,
    input  wire logic [ADDR_W-1:0]    o_report_group,
    input  wire logic                 o_has_source,
    input  wire logic [ADDR_W-1:0]    o_report_source,
    input  wire logic [MAC_W-1:0]     o_mac_action,
    input  wire logic [MACLO_W-1:0]   o_mac_low_bits,
    input  wire logic [COUNT_W-1:0]   o_group_count,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [CFG_AW-1:0]    paddr,
    input  wire logic [CFG_DW-1:0]    pwdata,
    input  wire logic                 pready,
    output int                        n_mismatch,
    output int                        n_pending
);

    localparam int NG = MGM_MAX_GROUPS;
    localparam int NS = MGM_MAX_SRC;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                send_report;
        logic [RTYPE_W-1:0]  rec_kind;
        logic [ADDR_W-1:0]   report_group;
        logic                has_source;
        logic [ADDR_W-1:0]   report_source;
        logic [MAC_W-1:0]    mac_action;
        logic [MACLO_W-1:0]  mac_low_bits;
        logic [COUNT_W-1:0]  group_count;
    } t_outcome;

    logic                grp_used [NG];
    logic [ADDR_W-1:0]   grp_addr [NG];
    logic [REFS_W-1:0]   grp_refs [NG];
    logic                src_used [NG*NS];
    logic [ADDR_W-1:0]   src_ip   [NG*NS];
    logic [REFS_W-1:0]   src_refs [NG*NS];
    logic [COUNT_W-1:0]  held;
    logic                cfg_enable;
    logic                cfg_mac_ena;

    t_outcome pending_outcomes [$];
    int       n_results;

    function automatic int lookup_group(input logic [ADDR_W-1:0] addr);
        int hit;
        hit = -1;
        for (int k = NG - 1; k >= 0; k--)
            if (grp_used[k] && grp_addr[k] == addr) hit = k;
        return hit;
    endfunction

    function automatic int lookup_source(input int g, input logic [ADDR_W-1:0] addr);
        int hit;
        hit = -1;
        for (int k = NS - 1; k >= 0; k--)
            if (src_used[g*NS+k] && src_ip[g*NS+k] == addr) hit = g*NS + k;
        return hit;
    endfunction

    function automatic void drop_sources(input int g);
        for (int k = 0; k < NS; k++) src_used[g*NS+k] = 1'b0;
    endfunction

    // Apply one request to the local tables and return the result it must give.
    function automatic t_outcome membership_outcome(input logic f,
                                                    input logic [ADDR_W-1:0] grp,
                                                    input logic [ADDR_W-1:0] src);
        t_outcome r;
        int       g;
        int       s;
        bit       fresh;
        bit       src_gone;
        bit       grp_gone;
        r = '0;
        fresh = 1'b0;
        src_gone = 1'b0;
        grp_gone = 1'b0;
        if (cfg_enable) begin
            if (f == FUNC_JOIN) begin
                if (held >= NG) begin
                    r.status = STAT_TBL_FULL;
                end else begin
                    g = lookup_group(grp);
                    if (g >= 0) begin
                        if (grp_refs[g] != '1) grp_refs[g]++;
                    end else begin
                        g = 0;
                        for (int k = NG - 1; k >= 0; k--)
                            if (!grp_used[k]) g = k;
                        grp_used[g] = 1'b1;
                        grp_addr[g] = grp;
                        grp_refs[g] = REFS_W'(1);
                        drop_sources(g);
                        held++;
                        if (cfg_mac_ena) r.mac_action = MAC_ADD;
                        fresh = 1'b1;
                    end
                    if (src != '0) begin
                        s = lookup_source(g, src);
                        if (s >= 0) begin
                            if (src_refs[s] != '1) src_refs[s]++;
                            fresh = 1'b0;
                        end else begin
                            for (int k = NS - 1; k >= 0; k--)
                                if (!src_used[g*NS+k]) s = g*NS + k;
                            if (s < 0) begin
                                r.status = STAT_SRC_FULL;
                                fresh = 1'b0;
                            end else begin
                                src_used[s] = 1'b1;
                                src_ip[s]   = src;
                                src_refs[s] = REFS_W'(1);
                                fresh = 1'b1;
                            end
                        end
                    end
                    if (fresh) begin
                        r.send_report = 1'b1;
                        r.rec_kind    = (src == '0) ? REC_TO_EXCL : REC_ALLOW;
                    end
                end
            end else begin
                g = lookup_group(grp);
                if (g < 0) begin
                    r.status = STAT_NOT_FOUND;
                end else begin
                    if (src != '0) begin
                        s = lookup_source(g, src);
                        if (s >= 0) begin
                            if (src_refs[s] <= 1) begin
                                src_refs[s] = '0;
                                src_used[s] = 1'b0;
                                src_gone = 1'b1;
                            end else begin
                                src_refs[s]--;
                            end
                        end
                    end
                    if (grp_refs[g] <= 1) begin
                        grp_refs[g] = '0;
                        grp_used[g] = 1'b0;
                        drop_sources(g);
                        if (held > 0) held--;
                        if (cfg_mac_ena) r.mac_action = MAC_REMOVE;
                        grp_gone = 1'b1;
                    end else begin
                        grp_refs[g]--;
                    end
                    if (grp_gone || src_gone) begin
                        r.send_report = 1'b1;
                        r.rec_kind    = (src == '0) ? REC_TO_INCL : REC_BLOCK;
                    end
                end
            end
        end
        if (r.send_report) begin
            r.report_group = grp;
            if (src != '0) begin
                r.has_source = 1'b1;
                r.report_source = src;
            end
        end
        if (r.mac_action != MAC_NONE) r.mac_low_bits = grp[MACLO_W-1:0];
        r.group_count = held;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        n_mismatch++;
        $display("[%0t] result %0d: %s", $realtime, n_results, msg);
    endtask

    task automatic check_field(input string field, input logic [ADDR_W-1:0] got,
                               input logic [ADDR_W-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h, want %0h", field, got, want));
    endtask

    initial begin
        n_mismatch = 0;
        n_pending  = 0;
        n_results  = 0;
    end

    always @(posedge i_clk) begin : watch
        t_outcome seen;
        t_outcome want;
        if (!i_rst_n) begin
            for (int k = 0; k < NG; k++) grp_used[k] = 1'b0;
            for (int k = 0; k < NG*NS; k++) src_used[k] = 1'b0;
            held        = '0;
            cfg_enable  = 1'b1;
            cfg_mac_ena = 1'b1;
            pending_outcomes.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr[CFG_AW-1:2] == REG_ENABLE)  cfg_enable  = pwdata[0];
                if (paddr[CFG_AW-1:2] == REG_MAC_ENA) cfg_mac_ena = pwdata[0];
            end
            if (o_valid) begin
                seen = {o_status, o_send_report, o_rec_kind, o_report_group,
                        o_has_source, o_report_source, o_mac_action, o_mac_low_bits,
                        o_group_count};
                if (pending_outcomes.size() == 0) begin
                    report_mismatch("result with no request outstanding");
                end else begin
                    want = pending_outcomes.pop_front();
                    check_field("status",        seen.status,        want.status);
                    check_field("send_report",   seen.send_report,   want.send_report);
                    check_field("rec_kind",      seen.rec_kind,      want.rec_kind);
                    check_field("report_group",  seen.report_group,  want.report_group);
                    check_field("has_source",    seen.has_source,    want.has_source);
                    check_field("report_source", seen.report_source, want.report_source);
                    check_field("mac_action",    seen.mac_action,    want.mac_action);
                    check_field("mac_low_bits",  seen.mac_low_bits,  want.mac_low_bits);
                    check_field("group_count",   seen.group_count,   want.group_count);
                end
                n_results++;
            end
            if (start && !busy)
                pending_outcomes.push_back(
                    membership_outcome(i_func, i_group_addr, i_source_addr));
        end
        n_pending <= pending_outcomes.size();
    end

endmodule

### dv/tb_multicast_group_membership_table_top.sv
// Testbench top for the multicast group membership table: drives requests and
// APB register writes, and gives the verdict from the checker's mismatch count.
// Depends on mgm_pkg, multicast_group_membership_table_top and membership_checker.
module tb_multicast_group_membership_table_top;

    import mgm_pkg::*;

    localparam int N_GRP_POOL = 36;   // a little over the table size, so it fills
    localparam int N_SRC_POOL = 12;   // over the per-group list size, so lists fill

    // Directed addresses
    localparam logic [ADDR_W-1:0] GRP_A = 32'hE000_0001;
    localparam logic [ADDR_W-1:0] SRC_A = 32'h0A00_0001;
    localparam logic [ADDR_W-1:0] SRC_B = 32'hC0A8_0001;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic                 i_func;
    logic [ADDR_W-1:0]    i_group_addr;
    logic [ADDR_W-1:0]    i_source_addr;
    logic                 o_valid;
    logic [STATUS_W-1:0]  o_status;
    logic                 o_send_report;
    logic [RTYPE_W-1:0]   o_rec_kind;
    logic [ADDR_W-1:0]    o_report_group;
    logic                 o_has_source;
    logic [ADDR_W-1:0]    o_report_source;
    logic [MAC_W-1:0]     o_mac_action;
    logic [MACLO_W-1:0]   o_mac_low_bits;
    logic [COUNT_W-1:0]   o_group_count;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [CFG_AW-1:0]    paddr;
    logic [CFG_DW-1:0]    pwdata;
    logic [CFG_DW-1:0]    prdata;
    logic                 pready;

    int                   n_mismatch;
    int                   n_pending;
    int                   gap_pct;
    logic [ADDR_W-1:0]    grp_pool [N_GRP_POOL];
    logic [ADDR_W-1:0]    src_pool [N_SRC_POOL];

    multicast_group_membership_table_top u_top (.*);

    membership_checker u_checker (.*);

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Hard stop: far beyond the slowest correct run of a few hundred requests.
    initial begin
        #10_000_000;
        $display("multicast_group_membership_table_top: mismatch");
        $finish;
    end

    // Offer one request and hold it until the block takes it. Drop start only
    // when an idle gap is drawn, so a back-to-back request keeps start high.
    task automatic issue(input logic f, input logic [ADDR_W-1:0] grp,
                         input logic [ADDR_W-1:0] src);
        if ($urandom_range(99) < gap_pct) begin
            start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < gap_pct);
        end
        start         <= 1'b1;
        i_func        <= f;
        i_group_addr  <= grp;
        i_source_addr <= src;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // Drop start and wait until every result is in and the block is idle.
    task automatic settle();
        start <= 1'b0;
        @(posedge i_clk);
        while (n_pending != 0 || busy) @(posedge i_clk);
    endtask

    // APB write: setup cycle, then access cycle held until pready.
    task automatic write_reg(input logic idx, input logic [CFG_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_AW'({idx, 2'b00});
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Random requests: mostly joins and leaves drawn from small address pools so
    // that groups repeat, lists and the table fill, plus some fully random noise.
    task automatic random_burst(input int n_items, input int join_pct);
        logic              f;
        logic [ADDR_W-1:0] grp;
        logic [ADDR_W-1:0] src;
        for (int n = 0; n < n_items; n++) begin
            if ($urandom_range(99) < 8) begin
                f   = 1'($urandom_range(1));
                grp = $urandom;
                src = $urandom;
            end else begin
                f   = ($urandom_range(99) < join_pct) ? FUNC_JOIN : FUNC_LEAVE;
                grp = grp_pool[$urandom_range(N_GRP_POOL - 1)];
                src = ($urandom_range(99) < 35) ? '0 : src_pool[$urandom_range(N_SRC_POOL - 1)];
            end
            issue(f, grp, src);
        end
    endtask

    initial begin
        start         <= 1'b0;
        i_func        <= FUNC_JOIN;
        i_group_addr  <= '0;
        i_source_addr <= '0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        i_rst_n       <= 1'b0;
        gap_pct        = 34;

        // Source pool keeps clear of the any-source and all-ones values used below.
        for (int k = 0; k < N_GRP_POOL; k++) grp_pool[k] = $urandom;
        for (int k = 0; k < N_SRC_POOL; k++)
            do src_pool[k] = $urandom; while (src_pool[k] == '0 || src_pool[k] == '1);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_reg(REG_ENABLE, 1);
        write_reg(REG_MAC_ENA, 1);

        // Directed: one group through its whole life, then a full source list.
        issue(FUNC_LEAVE, GRP_A, '0);       // leave against an empty table
        issue(FUNC_JOIN,  GRP_A, '0);       // new group, any source
        issue(FUNC_JOIN,  GRP_A, '0);       // repeat join, count only
        issue(FUNC_JOIN,  GRP_A, SRC_A);    // new source on a known group
        issue(FUNC_JOIN,  GRP_A, SRC_A);    // repeat source
        issue(FUNC_LEAVE, GRP_A, SRC_B);    // source never joined
        issue(FUNC_LEAVE, GRP_A, SRC_A);    // source count down, not freed
        issue(FUNC_LEAVE, GRP_A, SRC_A);    // source freed
        issue(FUNC_LEAVE, GRP_A, '0);       // group freed, filter removed
        issue(FUNC_JOIN,  '1, '1);          // all-ones group and source
        issue(FUNC_JOIN,  '0, '0);          // all-zeros group
        for (int k = 0; k < 7; k++) issue(FUNC_JOIN, '1, src_pool[k]);
        issue(FUNC_JOIN,  '1, src_pool[7]); // source list already holds eight
        issue(FUNC_JOIN,  '1, '0);
        issue(FUNC_LEAVE, '0, '0);
        issue(FUNC_LEAVE, '1, '1);

        // Filter control off, join-heavy so the table reaches full.
        settle();
        write_reg(REG_MAC_ENA, 0);
        random_burst(150, 75);

        // Block disabled: every request is a no-op.
        settle();
        gap_pct = 76;
        write_reg(REG_ENABLE, 0);
        random_burst(30, 60);

        settle();
        write_reg(REG_ENABLE, 1);
        write_reg(REG_MAC_ENA, 1);
        random_burst(130, 55);

        // Both registers low, then both high again with no sender gaps.
        settle();
        gap_pct = 0;
        write_reg(REG_ENABLE, 0);
        write_reg(REG_MAC_ENA, 0);
        random_burst(20, 50);

        settle();
        write_reg(REG_ENABLE, 1);
        write_reg(REG_MAC_ENA, 1);
        random_burst(100, 50);

        // Drain, then allow a full request latency for any stray result.
        settle();
        repeat (MGM_MAX_GROUPS + MGM_MAX_SRC + 16) @(posedge i_clk);
        if (n_mismatch == 0 && n_pending == 0) begin
            $display("multicast_group_membership_table_top: match");
        end else begin
            $display("multicast_group_membership_table_top: mismatch");
        end
        $finish;
    end

endmodule
